FILE: src/gsmsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmsu_pkg
// Shared types and constants of the GSM septet unpacker: the septet entry
// that moves from the unpacking front end to the escape back end, and the
// extension table lookup.
// ----------------------------------------------------------------------------
package gsmsu_pkg;

  localparam logic [6:0] EscSeptet  = 7'h1B;
  localparam logic [7:0] EscChar    = 8'h1B;
  localparam int unsigned SeptetW   = 7;

  // One septet that counts toward the message.
  typedef struct packed {
    logic                clr;     // first septet of a new message
    logic                last;    // final counted septet of the message
    logic [SeptetW-1:0]  septet;
  } sept_entry_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] chr;
  } ext_map_t;

  // Extension table: septet that follows an escape -> mapped character.
  function automatic ext_map_t ext_lookup(logic [SeptetW-1:0] s);
    ext_map_t r;
    r.hit = 1'b1;
    case (s)
      7'h14:   r.chr = 8'h5E;
      7'h28:   r.chr = 8'h7B;
      7'h29:   r.chr = 8'h7D;
      7'h2F:   r.chr = 8'h5C;
      7'h3C:   r.chr = 8'h5B;
      7'h3D:   r.chr = 8'h7E;
      7'h3E:   r.chr = 8'h5D;
      7'h40:   r.chr = 8'h7C;
      7'h65:   r.chr = 8'h80;
      default: begin
        r.hit = 1'b0;
        r.chr = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: src/gsmsu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmsu_front
// Accepts packed bytes, unpacks them into septets with the carried bits,
// counts septets against the message length and queues the counted ones.
// ----------------------------------------------------------------------------
module gsmsu_front #(
  parameter int MAX_SEPTETS = 160
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             packed_byte_i,
  input  logic                   first_byte_i,
  input  logic [7:0]             message_septets_i,
  output logic                   push_o,
  output gsmsu_pkg::sept_entry_t push_entry_o,
  input  logic                   full_i
);
  import gsmsu_pkg::*;

  localparam logic [7:0] MaxCnt = 8'(MAX_SEPTETS);

  logic [2:0]  grp_q, grp_d;
  logic [6:0]  carry_q, carry_d;
  logic [7:0]  left_q, left_d;
  logic        hold_q, hold_d;
  sept_entry_t hold_entry_q, hold_entry_d;

  logic        accept;
  logic [2:0]  g_eff;
  logic [3:0]  g_next;
  logic [6:0]  c_eff;
  logic [7:0]  left_eff, left1, cnt_sat;
  logic [14:0] shl;
  logic [7:0]  shr;
  logic [6:0]  s1, carry_new;

  assign in_ready_o = !hold_q && !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cnt_sat   = (message_septets_i > MaxCnt) ? MaxCnt : message_septets_i;
    g_eff     = first_byte_i ? 3'd0 : grp_q;
    c_eff     = first_byte_i ? 7'd0 : carry_q;
    left_eff  = first_byte_i ? cnt_sat : left_q;
    shl       = {7'd0, packed_byte_i} << g_eff;
    s1        = shl[6:0] | c_eff;
    shr       = packed_byte_i >> (3'd7 - g_eff);
    carry_new = shr[6:0];
    g_next    = {1'b0, g_eff} + 4'd1;
    left1     = (left_eff != 8'd0) ? (left_eff - 8'd1) : left_eff;

    push_o       = 1'b0;
    push_entry_o = hold_entry_q;
    if (hold_q) begin
      push_o = !full_i;
    end else if (accept && (left_eff != 8'd0)) begin
      push_o              = 1'b1;
      push_entry_o.clr    = first_byte_i;
      push_entry_o.last   = (left_eff == 8'd1);
      push_entry_o.septet = s1;
    end

    grp_d        = grp_q;
    carry_d      = carry_q;
    left_d       = left_q;
    hold_d       = hold_q && full_i;
    hold_entry_d = hold_entry_q;
    if (accept) begin
      if (g_next == 4'd7) begin
        // seventh byte of a group releases an eighth septet from its carry
        grp_d   = 3'd0;
        carry_d = 7'd0;
        if (left1 != 8'd0) begin
          hold_d              = 1'b1;
          hold_entry_d.clr    = 1'b0;
          hold_entry_d.last   = (left1 == 8'd1);
          hold_entry_d.septet = carry_new;
          left_d              = left1 - 8'd1;
        end else begin
          left_d = left1;
        end
      end else begin
        grp_d   = g_next[2:0];
        carry_d = carry_new;
        left_d  = left1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q        <= '0;
      carry_q      <= '0;
      left_q       <= '0;
      hold_q       <= 1'b0;
      hold_entry_q <= '0;
    end else begin
      grp_q        <= grp_d;
      carry_q      <= carry_d;
      left_q       <= left_d;
      hold_q       <= hold_d;
      hold_entry_q <= hold_entry_d;
    end
  end

  a_hold_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> !in_ready_o) else $error("input taken while eighth septet waits");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("septet pushed into full queue");

endmodule

FILE: src/gsmsu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmsu_fifo
// Two-entry queue of septet entries between front and back end.
// ----------------------------------------------------------------------------
module gsmsu_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  gsmsu_pkg::sept_entry_t push_entry_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output gsmsu_pkg::sept_entry_t head_o
);
  import gsmsu_pkg::*;

  sept_entry_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

FILE: src/gsmsu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmsu_back
// Resolves escape pairs on the septet stream and drives the output register,
// one character per cycle when not stalled; a pair's second waits in a slot.
// ----------------------------------------------------------------------------
module gsmsu_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  gsmsu_pkg::sept_entry_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             character_o,
  output logic                   end_of_message_o
);
  import gsmsu_pkg::*;

  logic       esc_q;
  logic       out_valid_q;
  logic [7:0] out_chr_q;
  logic       out_eom_q;
  logic       second_q;
  logic [7:0] second_chr_q;
  logic       second_eom_q;

  logic       slot_free, esc_eff, esc_next, is_esc;
  logic [1:0] n_res;
  logic [7:0] r1, r2;
  logic       e1, e2;
  ext_map_t   ext;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = valid_i && slot_free && !second_q;

  always_comb begin
    esc_eff  = esc_q && !head_i.clr;   // a new message drops a stale escape
    is_esc   = (head_i.septet == EscSeptet);
    ext      = ext_lookup(head_i.septet);
    n_res    = 2'd0;
    r1       = {1'b0, head_i.septet};
    r2       = {1'b0, head_i.septet};
    e1       = 1'b0;
    e2       = 1'b0;
    esc_next = 1'b0;
    if (esc_eff && ext.hit) begin
      n_res = 2'd1;
      r1    = ext.chr;
      e1    = head_i.last;
    end else if (esc_eff) begin
      // escape passes through, septet handled on its own
      r1 = EscChar;
      if (is_esc && !head_i.last) begin
        n_res    = 2'd1;
        esc_next = 1'b1;
      end else begin
        n_res = 2'd2;
        r2    = is_esc ? EscChar : {1'b0, head_i.septet};
        e2    = head_i.last;
      end
    end else if (is_esc) begin
      if (head_i.last) begin
        n_res = 2'd1;
        r1    = EscChar;
        e1    = 1'b1;
      end else begin
        esc_next = 1'b1;
      end
    end else begin
      n_res = 2'd1;
      e1    = head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_chr_q    <= '0;
      out_eom_q    <= 1'b0;
      second_q     <= 1'b0;
      second_chr_q <= '0;
      second_eom_q <= 1'b0;
    end else begin
      if (slot_free && second_q) begin
        out_valid_q <= 1'b1;
        out_chr_q   <= second_chr_q;
        out_eom_q   <= second_eom_q;
        second_q    <= 1'b0;
      end else if (pop_o) begin
        esc_q        <= esc_next;
        out_valid_q  <= (n_res != 2'd0);
        out_chr_q    <= r1;
        out_eom_q    <= e1;
        second_q     <= (n_res == 2'd2);
        second_chr_q <= r2;
        second_eom_q <= e2;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign character_o      = out_chr_q;
  assign end_of_message_o = out_eom_q;

  a_second_behind_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> out_valid_q) else $error("second character without first");

  a_second_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(second_q) |-> $past(pop_o)) else $error("second slot filled without pop");

endmodule

FILE: src/gsm_septet_unpack_escape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_septet_unpack_escape
// GSM 7-bit default alphabet unpacker with escape-pair resolution.
// ----------------------------------------------------------------------------
// Feed packed SMS user-data bytes on the slave stream, with tuser high on the
// first byte of a message and the message length in septets in tdata[15:8]
// of that byte (values above MAX_SEPTETS saturate). Each byte yields one
// septet; the seventh byte of every group yields a second one from its carry.
// Septets past the count are dropped. The escape 0x1B followed by an
// extension code comes out as one mapped character; otherwise the escape
// passes through as 0x1B. tlast marks the message's final character,
// including a trailing escape. Rate: a byte can be accepted every cycle,
// except the cycle after the seventh byte of a group, in which that byte's
// eighth septet enters the queue when it still counts (8 septets per
// 7 bytes); a full queue also holds the input. The back end sends at most
// one character per cycle, held while the receiver is not ready; an escape
// passing through with a following character yields two characters. A
// two-entry septet queue lets input and output stall independently.
// ----------------------------------------------------------------------------
module gsm_septet_unpack_escape #(
  parameter int MAX_SEPTETS = 160
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] packed_byte, [15:8] message_septets
  input  logic        s_axis_tuser,   // [0] first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] character
  output logic        m_axis_tlast    // end_of_message
);
  import gsmsu_pkg::*;

  // front end to queue
  logic        push, full;
  sept_entry_t push_entry;
  // queue to back end
  logic        pop, q_valid;
  sept_entry_t head;

  gsmsu_front #(
    .MAX_SEPTETS (MAX_SEPTETS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .packed_byte_i     (s_axis_tdata[7:0]),
    .first_byte_i      (s_axis_tuser),
    .message_septets_i (s_axis_tdata[15:8]),
    .push_o            (push),
    .push_entry_o      (push_entry),
    .full_i            (full)
  );

  gsmsu_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (head)
  );

  gsmsu_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (q_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .character_o      (m_axis_tdata),
    .end_of_message_o (m_axis_tlast)
  );

endmodule

FILE: verif/gsmsu_char_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsmsu_char_check
// Watches both streams of the septet unpacker. It keeps its own unpack and
// escape state, turns every accepted byte into the characters it should
// yield, and compares each accepted character against the oldest one due.
// ----------------------------------------------------------------------------
module gsmsu_char_check #(
  parameter int MAX_SEPTETS = 160
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] in_data_i,    // [7:0] packed_byte, [15:8] message_septets
  input  logic        in_first_i,   // [0] first_byte
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_char_i,   // [7:0] character
  input  logic        out_last_i,   // end_of_message
  output int          fail_cnt_o,
  output int          chars_due_o
);

  import gsmsu_pkg::*;

  typedef struct packed {
    logic [7:0] chr;
    logic       eom;
  } due_char_t;

  due_char_t  chars_due_q[$];

  // unpack and escape state
  logic [2:0] grp_pos;
  logic [6:0] carry;
  logic       esc_wait;
  logic [7:0] sept_left;

  // characters produced by the byte being decoded
  logic [7:0] step_chr [3];
  int         step_n;
  logic       step_end;

  int         fails;
  due_char_t  head;
  logic [6:0] sept;
  logic [14:0] shifted;
  int         cnt;

  // septet after an escape -> {hit, mapped character}
  function automatic logic [8:0] ext_map(logic [6:0] s);
    case (s)
      7'h14:   return {1'b1, 8'h5E};
      7'h28:   return {1'b1, 8'h7B};
      7'h29:   return {1'b1, 8'h7D};
      7'h2F:   return {1'b1, 8'h5C};
      7'h3C:   return {1'b1, 8'h5B};
      7'h3D:   return {1'b1, 8'h7E};
      7'h3E:   return {1'b1, 8'h5D};
      7'h40:   return {1'b1, 8'h7C};
      7'h65:   return {1'b1, 8'h80};
      default: return 9'h000;
    endcase
  endfunction

  task automatic emit_char(input logic [7:0] c);
    step_chr[step_n] = c;
    step_n++;
  endtask

  task automatic take_septet(input logic [6:0] s);
    logic [8:0] m;
    logic       mapped;
    mapped = 1'b0;
    if (sept_left != 8'd0) begin
      sept_left = sept_left - 8'd1;
      if (esc_wait) begin
        esc_wait = 1'b0;
        m = ext_map(s);
        if (m[8]) begin
          emit_char(m[7:0]);
          mapped = 1'b1;
        end else begin
          emit_char(EscChar);
        end
      end
      if (!mapped) begin
        if (s == EscSeptet) esc_wait = 1'b1;
        else emit_char({1'b0, s});
      end
      if (sept_left == 8'd0) begin
        // trailing escape is flushed as itself
        if (esc_wait) begin
          esc_wait = 1'b0;
          emit_char(EscChar);
        end
        step_end = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_pos   = '0;
      carry     = '0;
      esc_wait  = 1'b0;
      sept_left = '0;
      fails     = 0;
      chars_due_q.delete();
    end else begin
      // predict first, so a character out on the same edge still finds its entry
      if (in_valid_i && in_ready_i) begin
        step_n   = 0;
        step_end = 1'b0;
        if (in_first_i) begin
          cnt = int'(in_data_i[15:8]);
          if (cnt > MAX_SEPTETS) cnt = MAX_SEPTETS;
          grp_pos   = '0;
          carry     = '0;
          esc_wait  = 1'b0;
          sept_left = cnt[7:0];
        end
        shifted = {7'd0, in_data_i[7:0]} << grp_pos;
        sept    = shifted[6:0] | carry;
        carry   = 7'(in_data_i[7:0] >> (3'd7 - grp_pos));
        grp_pos = grp_pos + 3'd1;
        take_septet(sept);
        // seventh byte of a group also releases its carry as a septet
        if (grp_pos == 3'd7) begin
          sept    = carry;
          grp_pos = '0;
          carry   = '0;
          take_septet(sept);
        end
        for (int k = 0; k < step_n; k++)
          chars_due_q.push_back('{chr: step_chr[k], eom: step_end && (k == step_n - 1)});
      end

      if (out_valid_i && out_ready_i) begin
        if (chars_due_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t ERROR: unexpected char 0x%02h last %0b", $realtime,
                     out_char_i, out_last_i);
        end else begin
          head = chars_due_q.pop_front();
          if (head.chr !== out_char_i || head.eom !== out_last_i) begin
            fails++;
            if (fails <= 10)
              $display("%0t ERROR: char exp 0x%02h last %0b, got 0x%02h last %0b",
                       $realtime, head.chr, head.eom, out_char_i, out_last_i);
          end
        end
      end
    end
    fail_cnt_o  = fails;
    chars_due_o = chars_due_q.size();
  end

endmodule

FILE: verif/tb_gsm_septet_unpack_escape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gsm_septet_unpack_escape
// Drives packed SMS user-data bytes into the septet unpacker: a directed set
// covering every extension code, escape corner cases, zero and saturated
// counts and stray bytes, then random messages (mostly well formed, some
// truncated, overlong or empty). Both streams idle at random; the receiver
// holds off once for a long stretch. Checking is done by gsmsu_char_check.
// ----------------------------------------------------------------------------
module tb_gsm_septet_unpack_escape;

  import gsmsu_pkg::*;

  localparam int MaxSept = 160;

  // extension codes, code k at bits [7k +: 7]
  localparam logic [62:0] ExtCodes = {7'h65, 7'h40, 7'h3E, 7'h3D, 7'h3C,
                                      7'h2F, 7'h29, 7'h28, 7'h14};

  // receiver stall modes
  localparam int RdyAlways  = 0;
  localparam int RdyCoin    = 1;
  localparam int RdyPattern = 2;

  typedef struct packed {
    logic [7:0] sept_cnt;
    logic [7:0] data;
    logic       first;
  } byte_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int          fail_cnt;
  int          chars_due;

  byte_item_t  byte_items[$];
  logic [6:0]  sept_buf [MaxSept];

  logic        s_fire    = 1'b0;
  int          acc_items = 0;

  gsm_septet_unpack_escape #(
    .MAX_SEPTETS(MaxSept)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  gsmsu_char_check #(
    .MAX_SEPTETS(MaxSept)
  ) i_check (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_i  (m_axis_tdata),
    .out_last_i  (m_axis_tlast),
    .fail_cnt_o  (fail_cnt),
    .chars_due_o (chars_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // input handshakes, seen by the driver at the next falling edge
  always @(posedge clk_i) begin
    s_fire <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) acc_items <= acc_items + 1;
  end

  initial begin
    #(2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [6:0] pick_septet();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return EscSeptet;
    if (r < 40) return ExtCodes[7*$urandom_range(0, 8) +: 7];
    if (r < 45) return $urandom_range(0, 1) ? 7'h7F : 7'h00;
    return 7'($urandom_range(0, 127));
  endfunction

  // packs sept_buf[0..nsept-1] into nbytes bytes; bits past the septets are random
  task automatic queue_message(input logic [7:0] cnt_field, input int nsept,
                               input int nbytes);
    logic [1279:0] bits;
    byte_item_t    it;
    for (int w = 0; w < 40; w++) bits[32*w +: 32] = $urandom();
    for (int k = 0; k < nsept; k++) bits[7*k +: 7] = sept_buf[k];
    for (int k = 0; k < nbytes; k++) begin
      it.first    = (k == 0);
      it.sept_cnt = (k == 0) ? cnt_field : 8'($urandom());
      it.data     = bits[8*k +: 8];
      byte_items.push_back(it);
    end
  endtask

  task automatic queue_stray(input logic [7:0] b);
    byte_item_t it;
    it.first    = 1'b0;
    it.sept_cnt = 8'($urandom());
    it.data     = b;
    byte_items.push_back(it);
  endtask

  // receiver: random stall modes, plus one long hold-off once input is flowing
  initial begin
    int         mode;
    int         mode_left;
    int         hold_cnt;
    logic [7:0] pat;
    m_axis_tready = 1'b0;
    mode_left     = 0;
    hold_cnt      = 0;
    mode          = RdyAlways;
    pat           = 8'h01;
    forever begin
      @(negedge clk_i);
      if (acc_items >= 60 && hold_cnt < 200) begin
        // sender keeps offering, so the septet queue fills and input stalls
        m_axis_tready <= 1'b0;
        hold_cnt++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(RdyAlways, RdyPattern);
          mode_left = $urandom_range(16, 64);
          pat       = 8'($urandom_range(1, 255));
        end
        mode_left--;
        case (mode)
          RdyAlways: m_axis_tready <= 1'b1;
          RdyCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
          default: begin
            m_axis_tready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
      end
    end
  end

  // stimulus build, sender and verdict
  initial begin
    byte_item_t it;
    int         idx;
    int         burst_left;
    int         gap_left;
    int         n_rand;
    int         long_at;
    logic       long_done;
    int         kind;
    int         nsept;
    int         nbytes;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;

    // Directed: byte before any message start -> dropped
    queue_stray(8'hFF);
    // empty message, count field all zeros
    queue_message(8'h00, 0, 1);
    // count 255 saturates; escape left pending, then abandoned by the next start
    sept_buf[0] = 7'h7F;
    sept_buf[1] = EscSeptet;
    queue_message(8'hFF, 2, 2);
    // every extension pair, escape-escape, escape before a plain septet,
    // escape as the last counted septet
    for (int k = 0; k < 9; k++) begin
      sept_buf[2*k]   = EscSeptet;
      sept_buf[2*k+1] = ExtCodes[7*k +: 7];
    end
    sept_buf[18] = EscSeptet;
    sept_buf[19] = EscSeptet;
    sept_buf[20] = 7'h41;
    sept_buf[21] = EscSeptet;
    queue_message(8'd22, 22, 20);

    // Random messages, one of them at full saturated length; the byte total
    // counts the directed bytes as well
    n_rand    = byte_items.size();
    long_done = 1'b0;
    long_at   = $urandom_range(30, 60);
    while (n_rand < 220) begin
      if (!long_done && n_rand >= long_at) begin
        for (int k = 0; k < MaxSept; k++) sept_buf[k] = pick_septet();
        queue_message(8'($urandom_range(MaxSept, 255)), MaxSept, (7*MaxSept + 7) / 8);
        n_rand += (7*MaxSept + 7) / 8;
        long_done = 1'b1;
      end
      kind  = $urandom_range(0, 19);
      nsept = $urandom_range(1, 24);
      for (int k = 0; k < nsept; k++) sept_buf[k] = pick_septet();
      if (kind < 14) begin
        nbytes = (7*nsept + 7) / 8;
        queue_message(8'(nsept), nsept, nbytes);
      end else if (kind < 16) begin
        // trailing bytes past the count
        nbytes = (7*nsept + 7) / 8 + $urandom_range(1, 3);
        queue_message(8'(nsept), nsept, nbytes);
      end else if (kind < 18) begin
        // cut short, abandoned by the next start
        if (nsept < 2) nsept = 2;
        nbytes = $urandom_range(1, (7*nsept + 7) / 8 - 1);
        queue_message(8'(nsept), nsept, nbytes);
      end else if (kind == 18) begin
        nbytes = $urandom_range(1, 2);
        queue_message(8'h00, 0, nbytes);
      end else begin
        nbytes = $urandom_range(1, 3);
        for (int k = 0; k < nbytes; k++) queue_stray(8'($urandom()));
      end
      n_rand += nbytes;
    end

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // sender: bursts of random length with random gaps between them
    idx        = 0;
    burst_left = $urandom_range(1, 16);
    gap_left   = 0;
    while (idx < byte_items.size()) begin
      @(negedge clk_i);
      if (s_fire) begin
        idx++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (s_axis_tvalid && !s_fire) begin
        // item still waiting for tready, hold it
      end else if (idx >= byte_items.size()) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        it = byte_items[idx];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.sept_cnt, it.data};
        s_axis_tuser  <= it.first;
      end
    end

    while (chars_due != 0) @(negedge clk_i);
    // room for any stray character the block might still send
    repeat (40) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
